### hdl/gcpu_pkg.sv
// ----------------------------------------------------------------------------
// gcpu_pkg
// Shared types and constants for the per-unit GC content block.
// ----------------------------------------------------------------------------
package gcpu_pkg;

    localparam int UNIT_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_UP = 8'h47;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_GC,
        CLS_AT,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic unit_end;
    } item_t;

    typedef enum logic [1:0] {
        BK_COUNT,
        BK_SETUP,
        BK_DIVIDE,
        BK_DELIVER
    } back_state_t;

    // a separator that closes a unit is not counted
    function automatic cls_t classify(input logic [7:0] ch, input logic sep,
                                      input logic last);
        cls_t c;
        if (sep)
        begin
            c = last ? CLS_NONE : CLS_OTHER;
        end
        else
        begin
            case (ch)
                CHAR_G_UP, CHAR_G_LO, CHAR_C_UP, CHAR_C_LO: c = CLS_GC;
                CHAR_A_UP, CHAR_A_LO, CHAR_T_UP, CHAR_T_LO: c = CLS_AT;
                default:                                    c = CLS_OTHER;
            endcase
        end
        return c;
    endfunction

endpackage

### hdl/gcpu_front.sv
// ----------------------------------------------------------------------------
// gcpu_front
// Input stage: takes items, classifies the character and hands the class on.
// ----------------------------------------------------------------------------
module gcpu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      base_char,
    input  logic            is_separator,
    input  logic            unit_end,
    output logic            push,
    output gcpu_pkg::item_t push_item,
    input  logic            full
);
    import gcpu_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t front_item_reg;
    item_t front_item_next;
    logic  take;

    assign in_ready  = !front_valid_reg || !full;
    assign take      = in_valid && in_ready;
    assign push      = front_valid_reg && !full;
    assign push_item = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (take)
        begin
            front_valid_next         = 1'b1;
            front_item_next.cls      = classify(base_char, is_separator, unit_end);
            front_item_next.unit_end = unit_end;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

### hdl/gcpu_queue.sv
// ----------------------------------------------------------------------------
// gcpu_queue
// Short FIFO of classified items between the input stage and the counters.
// ----------------------------------------------------------------------------
module gcpu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcpu_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output gcpu_pkg::item_t pop_item,
    output logic            not_empty
);
    import gcpu_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/gcpu_back.sv
// ----------------------------------------------------------------------------
// gcpu_back
// Unit counters, bit-serial fraction divider and result register.
// ----------------------------------------------------------------------------
module gcpu_back #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              count_special,
    input  logic                              q_valid,
    input  gcpu_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [FRACTION_BITS:0]            gc_fraction,
    output logic [gcpu_pkg::UNIT_W-1:0]       unit_number,
    output logic                              zero_divisor
);
    import gcpu_pkg::*;

    localparam int DEN_W  = COUNT_WIDTH + 2;
    localparam int QUO_W  = FRACTION_BITS + 1;
    localparam int STEP_W = $clog2(FRACTION_BITS);

    back_state_t             state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  gc_reg, gc_next;
    logic [COUNT_WIDTH-1:0]  at_reg, at_next;
    logic [COUNT_WIDTH-1:0]  other_reg, other_next;
    logic [UNIT_W-1:0]       unit_reg, unit_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic                    zero_reg, zero_next;
    logic [UNIT_W-1:0]       res_unit_reg, res_unit_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [QUO_W-1:0]        out_frac_reg, out_frac_next;
    logic [UNIT_W-1:0]       out_unit_reg, out_unit_next;
    logic                    out_zero_reg, out_zero_next;
    logic [DEN_W:0]          rem_shift;
    logic                    rest_empty;

    assign q_pop        = (state_reg == BK_COUNT) && q_valid;
    assign rem_shift    = {rem_reg, 1'b0};
    // nothing besides gc in the divisor
    assign rest_empty   = (at_reg == '0) && (!count_special || other_reg == '0);
    assign out_valid    = out_valid_reg;
    assign gc_fraction  = out_frac_reg;
    assign unit_number  = out_unit_reg;
    assign zero_divisor = out_zero_reg;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        gc_next        = gc_reg;
        at_next        = at_reg;
        other_next     = other_reg;
        unit_next      = unit_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        zero_next      = zero_reg;
        res_unit_next  = res_unit_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_frac_next  = out_frac_reg;
        out_unit_next  = out_unit_reg;
        out_zero_next  = out_zero_reg;

        case (state_reg)
            BK_COUNT:
            begin
                if (q_valid)
                begin
                    case (q_item.cls)
                        CLS_GC:    gc_next    = sat_inc(gc_reg);
                        CLS_AT:    at_next    = sat_inc(at_reg);
                        CLS_OTHER: other_next = sat_inc(other_reg);
                        default:   ;
                    endcase
                    if (q_item.unit_end)
                    begin
                        state_next = BK_SETUP;
                    end
                end
            end
            BK_SETUP:
            begin
                den_next = DEN_W'(gc_reg) + DEN_W'(at_reg)
                         + (count_special ? DEN_W'(other_reg) : DEN_W'(0));
                zero_next = (gc_reg == '0) && rest_empty;
                // gc equal to the divisor: integer part is one, remainder zero
                if (gc_reg != '0 && rest_empty)
                begin
                    quo_next = QUO_W'(1);
                    rem_next = '0;
                end
                else
                begin
                    quo_next = '0;
                    rem_next = DEN_W'(gc_reg);
                end
                res_unit_next = unit_reg;
                unit_next     = unit_reg + 1'b1;
                gc_next       = '0;
                at_next       = '0;
                other_next    = '0;
                step_next     = '0;
                state_next    = ((gc_reg == '0) && rest_empty) ? BK_DELIVER : BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = DEN_W'(rem_shift - {1'b0, den_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = DEN_W'(rem_shift);
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRACTION_BITS - 1))
                begin
                    state_next = BK_DELIVER;
                end
            end
            BK_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_frac_next  = zero_reg ? '0 : quo_reg;
                    out_unit_next  = res_unit_reg;
                    out_zero_next  = zero_reg;
                    state_next     = BK_COUNT;
                end
            end
            default:
            begin
                state_next = BK_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_COUNT;
            gc_reg        <= '0;
            at_reg        <= '0;
            other_reg     <= '0;
            unit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gc_reg        <= gc_next;
            at_reg        <= at_next;
            other_reg     <= other_next;
            unit_reg      <= unit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        zero_reg     <= zero_next;
        res_unit_reg <= res_unit_next;
        step_reg     <= step_next;
        out_frac_reg <= out_frac_next;
        out_unit_reg <= out_unit_next;
        out_zero_reg <= out_zero_next;
    end

    a_zero_means_no_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |-> out_frac_reg == '0)
        else $error("zero divisor result carries a nonzero fraction");

    a_fraction_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_frac_reg <= (QUO_W'(1) << FRACTION_BITS))
        else $error("fraction above one");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIVIDE |-> den_reg != '0)
        else $error("divide step with zero divisor");

    a_unit_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.unit_end |=> state_reg == BK_SETUP && gc_reg == $past(gc_next))
        else $error("unit end item did not close the unit");

endmodule

### hdl/gc_content_per_unit.sv
// ----------------------------------------------------------------------------
// gc_content_per_unit
// Counts G/C and A/T per unit of a DNA character stream and reports the GC
// fraction in unsigned fixed point (1.0 = 2^FRACTION_BITS, truncated) with
// the unit number on each item that closes a unit. Characters are taken one
// per cycle; a four-deep item queue sits between the input stage and the
// counters. Each unit end holds the counters through divisor set-up, the
// restoring divider (one quotient bit per cycle) and result hand-off; a zero
// divisor skips the divider. Input stalls only once the queue fills.
// Results wait in an output register; hand-off, and with it the counters,
// stalls only when a second result is ready before the first is taken.
// count_special selects whole unit length (1) or G/C + A/T (0) as divisor and
// is to be written while the block is idle.
// ----------------------------------------------------------------------------
module gc_content_per_unit #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  base_char,
    input  logic                        is_separator,
    input  logic                        unit_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FRACTION_BITS:0]      gc_fraction,
    output logic [gcpu_pkg::UNIT_W-1:0] unit_number,
    output logic                        zero_divisor,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        count_special
);
    import gcpu_pkg::*;

    logic  count_special_reg;
    logic  count_special_next;
    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t pop_item;
    logic  not_empty;

    assign cfg_ready          = 1'b1;
    assign count_special_next = (cfg_valid && cfg_ready) ? count_special : count_special_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_special_reg <= 1'b0;
        end
        else
        begin
            count_special_reg <= count_special_next;
        end
    end

    gcpu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_char    (base_char),
        .is_separator (is_separator),
        .unit_end     (unit_end),
        .push         (push),
        .push_item    (push_item),
        .full         (full)
    );

    gcpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    gcpu_back #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .count_special (count_special_reg),
        .q_valid       (not_empty),
        .q_item        (pop_item),
        .q_pop         (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gc_fraction   (gc_fraction),
        .unit_number   (unit_number),
        .zero_divisor  (zero_divisor)
    );

endmodule
